>>> rtl/bhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Shared constants, operation and status codes, and the key ordering test.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  // Default sizing
  localparam int unsigned DEF_CAPACITY = 1024;
  localparam int unsigned DEF_TAG_BITS = 16;
  localparam int unsigned KEY_W        = 32;

  // Operation codes carried by mode_i
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // Completion codes reported on status_o
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // True when key a belongs strictly above key b
  function automatic logic beats(logic signed [KEY_W-1:0] a,
                                 logic signed [KEY_W-1:0] b,
                                 logic                    largest);
    return largest ? (a > b) : (a < b);
  endfunction

endpackage
`default_nettype wire

>>> rtl/bhpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heap entry RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int unsigned DEPTH  = bhpq_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_W = bhpq_pkg::KEY_W + bhpq_pkg::DEF_TAG_BITS,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic [AW-1:0]     rd_addr_a_i,
  input  wire logic [AW-1:0]     rd_addr_b_i,
  output logic      [DATA_W-1:0] rd_data_a_o,
  output logic      [DATA_W-1:0] rd_data_b_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write on enable, read both ports every cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule
`default_nettype wire

>>> rtl/binary_heap_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Array heap of signed keys with tags, held in a RAM, push / pop / clear.
// ----------------------------------------------------------------------------
// Usage:
//   Drive mode_i, key_i and tag_i and raise start_i; the request is taken at
//   a clock edge where start_i is high and busy_o is low. busy_o stays high
//   until the result has been shown. The result (status_o, top_valid_o, top_key_o,
//   top_tag_o, count_o) is valid for exactly the one cycle that done_o is
//   high; the receiver cannot stall it and must take it then.
//   Steps: clear, unused mode, rejected push, pop on empty and pop of the
//   last entry go straight to S_DONE; a push into an empty heap writes the
//   root in S_PLACE first. Otherwise a push climbs through S_UP_RD and
//   S_UP_CMP per level, ending in S_PLACE at the root or in S_UP_CMP when it
//   stops below it. A pop loads the last entry in S_POP_LOAD, then descends
//   through S_DN_RD and S_DN_CMP per level, ending in S_DN_RD at a leaf and
//   in S_DN_CMP above one. Each level has a read and a compare-and-write state.
//   One request is in flight at a time; the next may start the cycle after
//   done_o.
//   cfg_we_i writes the ordering bit (1 greatest key on top, 0 smallest);
//   write it only while idle. Reset empties the heap and selects greatest
//   first; RAM contents are not cleared, since only held entries are used.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_top #(
  parameter int unsigned CAPACITY = bhpq_pkg::DEF_CAPACITY,
  parameter int unsigned TAG_BITS = bhpq_pkg::DEF_TAG_BITS,
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [1:0]                         mode_i,
  input  wire logic signed [bhpq_pkg::KEY_W-1:0]  key_i,
  input  wire logic [TAG_BITS-1:0]                tag_i,
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_wdata_i,
  output logic                                    done_o,
  output logic [1:0]                              status_o,
  output logic                                    top_valid_o,
  output logic signed [bhpq_pkg::KEY_W-1:0]       top_key_o,
  output logic [TAG_BITS-1:0]                     top_tag_o,
  output logic [CW-1:0]                           count_o
);

  import bhpq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned DW = KEY_W + TAG_BITS;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_UP_RD    = 8'b0000_0010,
    S_UP_CMP   = 8'b0000_0100,
    S_POP_LOAD = 8'b0000_1000,
    S_DN_RD    = 8'b0001_0000,
    S_DN_CMP   = 8'b0010_0000,
    S_PLACE    = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  // Map a 1-based heap index onto a RAM address
  function automatic logic [AW-1:0] to_addr(logic [CW:0] idx);
    logic [CW:0] a;
    a = idx - 1'b1;
    return a[AW-1:0];
  endfunction

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          pos_q, pos_d;
  status_e                status_q, status_d;
  logic                   largest_q;
  logic signed [KEY_W-1:0] mov_key_q, mov_key_d;
  logic [TAG_BITS-1:0]    mov_tag_q, mov_tag_d;
  logic signed [KEY_W-1:0] root_key_q;
  logic [TAG_BITS-1:0]    root_tag_q;

  logic                   wr_en;
  logic [CW-1:0]          wr_idx;
  logic signed [KEY_W-1:0] wr_key;
  logic [TAG_BITS-1:0]    wr_tag;
  logic [CW:0]            rd_idx_a, rd_idx_b;
  logic [DW-1:0]          rd_data_a, rd_data_b;

  logic signed [KEY_W-1:0] rd_key_a, rd_key_b, child_key;
  logic [TAG_BITS-1:0]    rd_tag_a, rd_tag_b, child_tag;
  logic [CW:0]            left_idx, right_idx;
  logic                   has_left, has_right, take_right;
  logic [CW-1:0]          parent_idx;

  assign rd_key_a   = rd_data_a[DW-1 -: KEY_W];
  assign rd_tag_a   = rd_data_a[TAG_BITS-1:0];
  assign rd_key_b   = rd_data_b[DW-1 -: KEY_W];
  assign rd_tag_b   = rd_data_b[TAG_BITS-1:0];
  assign left_idx   = {pos_q, 1'b0};
  assign right_idx  = {pos_q, 1'b1};
  assign has_left   = left_idx <= {1'b0, count_q};
  assign has_right  = right_idx <= {1'b0, count_q};
  assign take_right = has_right && beats(rd_key_b, rd_key_a, largest_q);
  assign child_key  = take_right ? rd_key_b : rd_key_a;
  assign child_tag  = take_right ? rd_tag_b : rd_tag_a;
  assign parent_idx = pos_q >> 1;

  // Entry store
  bhpq_ram #(
    .DEPTH  (CAPACITY),
    .DATA_W (DW)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (to_addr({1'b0, wr_idx})),
    .wr_data_i   ({wr_key, wr_tag}),
    .rd_addr_a_i (to_addr(rd_idx_a)),
    .rd_addr_b_i (to_addr(rd_idx_b)),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  // Sequence a request: sift the held entry up or down a level at a time
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    status_d  = status_q;
    mov_key_d = mov_key_q;
    mov_tag_d = mov_tag_q;
    wr_en     = 1'b0;
    wr_idx    = pos_q;
    wr_key    = mov_key_q;
    wr_tag    = mov_tag_q;
    rd_idx_a  = left_idx;
    rd_idx_b  = right_idx;
    case (state_q)
      S_IDLE: begin
        rd_idx_a = {1'b0, count_q};
        if (start_i) begin
          status_d = ST_DONE;
          state_d  = S_DONE;
          case (mode_i)
            MODE_PUSH: begin
              if (count_q == CW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                count_d   = count_q + 1'b1;
                pos_d     = count_q + 1'b1;
                mov_key_d = key_i;
                mov_tag_d = tag_i;
                state_d   = (count_q == '0) ? S_PLACE : S_UP_RD;
              end
            end
            MODE_POP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
                pos_d   = CW'(1);
                if (count_q != CW'(1)) begin
                  state_d = S_POP_LOAD;
                end
              end
            end
            MODE_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_UP_RD: begin
        rd_idx_a = {1'b0, parent_idx};
        state_d  = S_UP_CMP;
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (beats(mov_key_q, rd_key_a, largest_q)) begin
          // move parent down into the hole
          wr_key  = rd_key_a;
          wr_tag  = rd_tag_a;
          pos_d   = parent_idx;
          state_d = (parent_idx == CW'(1)) ? S_PLACE : S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POP_LOAD: begin
        mov_key_d = rd_key_a;
        mov_tag_d = rd_tag_a;
        state_d   = S_DN_RD;
      end
      S_DN_RD: begin
        if (has_left) begin
          state_d = S_DN_CMP;
        end else begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (beats(child_key, mov_key_q, largest_q)) begin
          // move the better child up into the hole
          wr_key  = child_key;
          wr_tag  = child_tag;
          pos_d   = take_right ? right_idx[CW-1:0] : left_idx[CW-1:0];
          state_d = S_DN_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_PLACE: begin
        wr_en   = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      status_q  <= ST_DONE;
      largest_q <= 1'b1;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
      if (cfg_we_i) begin
        largest_q <= cfg_wdata_i;
      end
    end
  end

  // Held entry, position and root copy
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    mov_key_q <= mov_key_d;
    mov_tag_q <= mov_tag_d;
    if (wr_en && wr_idx == CW'(1)) begin
      root_key_q <= wr_key;
      root_tag_q <= wr_tag;
    end
  end

  // Result
  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign status_o    = status_q;
  assign top_valid_o = (count_q != '0);
  assign top_key_o   = top_valid_o ? root_key_q : '0;
  assign top_tag_o   = top_valid_o ? root_tag_q : '0;
  assign count_o     = count_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block still busy after result");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_PUSH && count_q != CW'(CAPACITY))
      |=> count_q == $past(count_q) + 1'b1)
    else $error("accepted push did not grow the heap");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_idx != '0 && wr_idx <= count_q))
    else $error("write outside held entries");

endmodule
`default_nettype wire
